### hdl/bt_pkg.sv
// Shared types, constants and the sequencer program of the balance tilt controller.
package bt_pkg;

    // Scale factors and filter coefficients (Q28 / Q30)
    localparam logic signed [31:0] GYRO_K28 = 32'sd1874033012;
    localparam logic signed [31:0] ACC_K28  = 32'sd1242756741;
    localparam logic signed [31:0] LP_B30   = 32'sd1014355;
    localparam logic signed [31:0] LP_A1_30 = 32'sd2052132225;
    localparam logic signed [31:0] LP_A0_30 = -32'sd982447822;
    localparam logic [31:0]        Y_FALL30 = 32'd107374182;
    localparam logic [31:0]        X_FALL30 = 32'd644245094;
    localparam logic [31:0]        X_ARM30  = 32'd21474836;

    localparam logic [9:0]  DIV_BY_TEN  = 10'd10;
    localparam logic [9:0]  DIV_BY_MS   = 10'd1000;
    localparam logic [9:0]  DIV_BY_GF   = 10'd20;
    localparam logic [15:0] DUTY_SAT_SQ = 16'd65025;
    localparam logic [7:0]  DUTY_MAX    = 8'd255;

    // ceil(2^32 / divisor) for each constant divisor
    localparam logic [29:0] RECIP_TEN = 30'd429496730;
    localparam logic [29:0] RECIP_MS  = 30'd4294968;
    localparam logic [29:0] RECIP_GF  = 30'd214748365;

    typedef enum logic [2:0] {
        REG_GYRO_TRIM,
        REG_ACCX_OFS,
        REG_TILT_GAIN,
        REG_RATE_GAIN,
        REG_INT_GAIN,
        REG_INT_LIMIT
    } reg_idx_t;

    typedef struct packed {
        logic [9:0]  gyro_offset_trim;
        logic [7:0]  accel_x_offset;
        logic [15:0] tilt_gain;
        logic [15:0] rate_gain;
        logic [15:0] integral_gain;
        logic [30:0] integral_limit;
    } bt_cfg_t;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_RATE, MUL_XG, MUL_XR, MUL_YG, MUL_LP_IN, MUL_LP_O0, MUL_LP_O1,
        MUL_TSQ_X, MUL_TSQ_Y, MUL_P, MUL_XGT, MUL_SPD_T, MUL_SPD_I, MUL_SPD_R
    } mul_sel_t;

    typedef enum logic [1:0] {ACC_HOLD, ACC_SET, ACC_ADD} acc_op_t;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_DIV_RATE, ACT_XG, ACT_XR, ACT_YG, ACT_XF, ACT_H, ACT_RATE,
        ACT_PDIV, ACT_GF, ACT_TNEW, ACT_INEW, ACT_COMMIT, ACT_SQRT, ACT_LOAD_OUT,
        ACT_LOAD_IN
    } act_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        act_t     act;
        logic     wait_div;
    } bt_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_done;
    } bt_stat_t;

    typedef logic [4:0] pc_t;
    localparam pc_t PROG_LAST = 5'd24;

    localparam bt_cmd_t CMD_NOP = '{MUL_NONE, ACC_HOLD, ACT_NONE, 1'b0};

    function automatic bt_cmd_t prog_step(input pc_t pc);
        bt_cmd_t c;
        c = CMD_NOP;
        case (pc)
            5'd0:  c = '{MUL_RATE,  ACC_HOLD, ACT_NONE,     1'b0};
            5'd1:  c = '{MUL_XG,    ACC_HOLD, ACT_DIV_RATE, 1'b0};
            5'd2:  c = '{MUL_XR,    ACC_HOLD, ACT_XG,       1'b0};
            5'd3:  c = '{MUL_YG,    ACC_HOLD, ACT_XR,       1'b0};
            5'd4:  c = '{MUL_LP_IN, ACC_HOLD, ACT_YG,       1'b0};
            5'd5:  c = '{MUL_LP_O0, ACC_SET,  ACT_NONE,     1'b0};
            5'd6:  c = '{MUL_LP_O1, ACC_ADD,  ACT_NONE,     1'b0};
            5'd7:  c = '{MUL_NONE,  ACC_ADD,  ACT_NONE,     1'b0};
            5'd8:  c = '{MUL_TSQ_X, ACC_HOLD, ACT_XF,       1'b0};
            5'd9:  c = '{MUL_TSQ_Y, ACC_SET,  ACT_NONE,     1'b0};
            5'd10: c = '{MUL_NONE,  ACC_ADD,  ACT_NONE,     1'b0};
            5'd11: c = '{MUL_NONE,  ACC_HOLD, ACT_H,        1'b0};
            5'd12: c = '{MUL_NONE,  ACC_HOLD, ACT_RATE,     1'b1};
            5'd13: c = '{MUL_NONE,  ACC_HOLD, ACT_PDIV,     1'b1};
            5'd14: c = '{MUL_NONE,  ACC_HOLD, ACT_GF,       1'b1};
            5'd15: c = '{MUL_P,     ACC_HOLD, ACT_NONE,     1'b0};
            5'd16: c = '{MUL_XGT,   ACC_SET,  ACT_NONE,     1'b0};
            5'd17: c = '{MUL_NONE,  ACC_ADD,  ACT_NONE,     1'b0};
            5'd18: c = '{MUL_NONE,  ACC_HOLD, ACT_TNEW,     1'b0};
            5'd19: c = '{MUL_NONE,  ACC_HOLD, ACT_INEW,     1'b0};
            5'd20: c = '{MUL_SPD_T, ACC_HOLD, ACT_NONE,     1'b0};
            5'd21: c = '{MUL_SPD_I, ACC_SET,  ACT_NONE,     1'b0};
            5'd22: c = '{MUL_SPD_R, ACC_ADD,  ACT_NONE,     1'b0};
            5'd23: c = '{MUL_NONE,  ACC_ADD,  ACT_NONE,     1'b0};
            5'd24: c = '{MUL_NONE,  ACC_HOLD, ACT_COMMIT,   1'b0};
            default: c = CMD_NOP;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### hdl/balance_tilt_controller.sv
// Top level of the balance tilt controller: stream ports, register file, core.
//
//  channel  | direction | payload
//  s_       | in        | gyro, accel X, accel Y samples
//  m_       | out       | direction, duty, armed, fallen
//  APB      | in/out    | six configuration registers
//
// One item runs from accept to m_tvalid through 25 program steps, two waits on the
// reciprocal divider (rate by 1000, weight by 20), the square root (one bit per
// cycle, none when the duty saturates) and one output load.
// The next item can be accepted in the cycle after the result is loaded.
// Reset is synchronous; it clears filter history, tilt, integral and armed.
// A new item is accepted while the previous result still waits on m_tready.
module balance_tilt_controller #(
    parameter int ADC_BITS  = 10,
    parameter int FRAC_BITS = 16,
    localparam int S_TDATA_W = ((3 * ADC_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // gyro_sample, accel_x_sample, accel_y_sample, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // direction[0], duty[8:1], armed[9], fallen[10], zero pad
    output logic [15:0]          m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import bt_pkg::*;

    bt_cfg_t  cfg_reg;
    bt_cmd_t  cmd;
    bt_stat_t stat;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gyro_offset_trim <= 10'd512;
            cfg_reg.accel_x_offset   <= 8'd8;
            cfg_reg.tilt_gain        <= 16'd20000;
            cfg_reg.rate_gain        <= 16'd100;
            cfg_reg.integral_gain    <= 16'd0;
            cfg_reg.integral_limit   <= 31'h7FFFFFFF;
        end else if (wr_en) begin
            case (idx)
                REG_GYRO_TRIM: cfg_reg.gyro_offset_trim <= pwdata[9:0];
                REG_ACCX_OFS:  cfg_reg.accel_x_offset   <= pwdata[7:0];
                REG_TILT_GAIN: cfg_reg.tilt_gain        <= pwdata[15:0];
                REG_RATE_GAIN: cfg_reg.rate_gain        <= pwdata[15:0];
                REG_INT_GAIN:  cfg_reg.integral_gain    <= pwdata[15:0];
                REG_INT_LIMIT: cfg_reg.integral_limit   <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GYRO_TRIM: prdata = {22'd0, cfg_reg.gyro_offset_trim};
            REG_ACCX_OFS:  prdata = {24'd0, cfg_reg.accel_x_offset};
            REG_TILT_GAIN: prdata = {16'd0, cfg_reg.tilt_gain};
            REG_RATE_GAIN: prdata = {16'd0, cfg_reg.rate_gain};
            REG_INT_GAIN:  prdata = {16'd0, cfg_reg.integral_gain};
            REG_INT_LIMIT: prdata = {1'b0, cfg_reg.integral_limit};
            default:       prdata = 32'd0;
        endcase
    end

    bt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bt_dp #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .gyro_sample    (s_tdata[ADC_BITS-1:0]),
        .accel_x_sample (s_tdata[2*ADC_BITS-1:ADC_BITS]),
        .accel_y_sample (s_tdata[3*ADC_BITS-1:2*ADC_BITS]),
        .stat           (stat),
        .out_data       (m_tdata)
    );
endmodule

### hdl/bt_div.sv
// Floor divider of a signed value by a constant divisor: reciprocal multiply and one fix-up.
module bt_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] value,
    input  logic [9:0]         divisor,
    output logic               busy,
    output logic signed [31:0] quot
);
    import bt_pkg::*;

    localparam logic [1:0] STEPS = 2'd3;

    logic signed [31:0] val_reg;
    logic [9:0]         d_reg;
    logic [29:0]        recip_reg;
    logic signed [62:0] prod_reg;
    logic signed [31:0] q0_reg;
    logic signed [31:0] quot_reg;
    logic [1:0]         cnt_reg;

    logic [29:0]        recip;
    logic signed [42:0] d_ext;
    logic signed [42:0] rem;

    always_comb begin
        unique case (divisor)
            DIV_BY_MS: recip = RECIP_MS;
            DIV_BY_GF: recip = RECIP_GF;
            default:   recip = RECIP_TEN;
        endcase
    end

    // the estimate is off by at most one either way; the remainder picks the fix
    assign d_ext = $signed({33'd0, d_reg});
    assign rem   = 43'(val_reg) - 43'(q0_reg) * d_ext;
    assign busy  = cnt_reg != 2'd0;
    assign quot  = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (start) begin
            cnt_reg <= STEPS;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg   <= value;
            d_reg     <= divisor;
            recip_reg <= recip;
        end
        prod_reg <= val_reg * $signed({1'b0, recip_reg});
        q0_reg   <= 32'(prod_reg >>> 32);
        if (rem < 0) begin
            quot_reg <= q0_reg - 32'sd1;
        end else if (rem >= d_ext) begin
            quot_reg <= q0_reg + 32'sd1;
        end else begin
            quot_reg <= q0_reg;
        end
    end
endmodule

### hdl/bt_dp.sv
// Datapath: shared multiplier, accumulator, filter and controller state, square root.
module bt_dp #(
    parameter int ADC_BITS  = 10,
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bt_pkg::bt_cfg_t      cfg,
    input  bt_pkg::bt_cmd_t      cmd,
    input  logic [ADC_BITS-1:0]  gyro_sample,
    input  logic [ADC_BITS-1:0]  accel_x_sample,
    input  logic [ADC_BITS-1:0]  accel_y_sample,
    output bt_pkg::bt_stat_t     stat,
    output logic [15:0]          out_data
);
    import bt_pkg::*;

    localparam int S  = 28 + ADC_BITS - FRAC_BITS;
    localparam int SF = 30 - FRAC_BITS;
    localparam logic signed [33:0] MID    = 34'(64'd1 << (ADC_BITS - 1));
    localparam logic signed [67:0] ONE    = 68'(64'd1 << FRAC_BITS);
    localparam logic signed [67:0] Y_FALL = 68'(Y_FALL30 >> SF);
    localparam logic signed [67:0] X_FALL = 68'(X_FALL30 >> SF);
    localparam logic signed [67:0] BAND   = 68'(X_ARM30 >> SF);

    logic [ADC_BITS-1:0] g_reg, x_reg, y_reg;
    logic signed [65:0]  prod_reg;
    logic signed [67:0]  acc_reg;
    logic signed [31:0]  xg_reg, xr_reg, yg_reg, xf_reg, rate_reg, pdiv_reg;
    logic signed [31:0]  gf_reg, h_reg, tnew_reg, inew_reg;
    logic signed [31:0]  tilt_reg, integ_reg, lp_in0_reg, lp_in1_reg, lp_out0_reg, lp_out1_reg;
    logic                armed_reg, fell_reg, dir_reg;
    logic [15:0]         mag_reg;
    logic [7:0]          root_reg, bit_reg;

    logic signed [33:0]  mul_a, g_ext, x_ext, y_ext;
    logic signed [31:0]  mul_b;
    logic signed [65:0]  prod_sh;
    logic signed [67:0]  xf_wide, tsq, dev, hv, speed, spd_mag, m49, msh, xfa;
    logic signed [31:0]  xf_next, tnew_next;
    logic signed [32:0]  isum, lim33, integ_next;
    logic                fell, arm_ok;
    logic [7:0]          sq_try;
    logic [15:0]         sq_prod;
    logic                div_start, div_busy;
    logic signed [31:0]  div_val, div_q;
    logic [9:0]          div_d;

    assign g_ext = $signed({{(34 - ADC_BITS){1'b0}}, g_reg});
    assign x_ext = $signed({{(34 - ADC_BITS){1'b0}}, x_reg});
    assign y_ext = $signed({{(34 - ADC_BITS){1'b0}}, y_reg});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_RATE: begin
                mul_a = 34'sd10 * (MID - g_ext)
                      + $signed({24'd0, cfg.gyro_offset_trim}) - 34'sd512;
                mul_b = GYRO_K28;
            end
            MUL_XG: begin
                mul_a = x_ext - MID + 34'($signed(cfg.accel_x_offset));
                mul_b = ACC_K28;
            end
            MUL_XR: begin
                mul_a = x_ext - MID;
                mul_b = ACC_K28;
            end
            MUL_YG: begin
                mul_a = y_ext - MID;
                mul_b = ACC_K28;
            end
            MUL_LP_IN: begin
                mul_a = 34'(lp_in0_reg) + (34'(lp_in1_reg) <<< 1) + 34'(xg_reg);
                mul_b = LP_B30;
            end
            MUL_LP_O0: begin
                mul_a = 34'(lp_out0_reg);
                mul_b = LP_A0_30;
            end
            MUL_LP_O1: begin
                mul_a = 34'(lp_out1_reg);
                mul_b = LP_A1_30;
            end
            MUL_TSQ_X: begin
                mul_a = 34'(xr_reg);
                mul_b = xr_reg;
            end
            MUL_TSQ_Y: begin
                mul_a = 34'(yg_reg);
                mul_b = yg_reg;
            end
            MUL_P: begin
                mul_a = 34'(tilt_reg) + 34'(pdiv_reg);
                mul_b = 32'(ONE) - gf_reg;
            end
            MUL_XGT: begin
                mul_a = 34'(xg_reg);
                mul_b = gf_reg;
            end
            MUL_SPD_T: begin
                mul_a = 34'(tnew_reg);
                mul_b = $signed({16'd0, cfg.tilt_gain});
            end
            MUL_SPD_I: begin
                mul_a = 34'(inew_reg);
                mul_b = $signed({16'd0, cfg.integral_gain});
            end
            MUL_SPD_R: begin
                mul_a = 34'(rate_reg);
                mul_b = $signed({16'd0, cfg.rate_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Scalar results of the step
    always_comb begin
        prod_sh   = prod_reg >>> S;
        xf_wide   = acc_reg >>> 30;
        xf_next   = sat32(xf_wide);
        tnew_next = sat32(acc_reg >>> FRAC_BITS);
        tsq       = acc_reg >>> FRAC_BITS;
        dev       = ONE - tsq;
        if (dev < 0) begin
            dev = -dev;
        end
        hv    = ONE - 68'sd100 * dev;
        isum  = 33'(integ_reg) + 33'(tnew_reg);
        lim33 = $signed({2'b00, cfg.integral_limit});
        integ_next = isum;
        if (isum > lim33) begin
            integ_next = lim33;
        end
        if (isum < -lim33) begin
            integ_next = -lim33;
        end
        xfa    = (xf_reg < 0) ? -68'(xf_reg) : 68'(xf_reg);
        fell   = (68'(yg_reg) < Y_FALL) && (xfa > X_FALL);
        arm_ok = (-BAND < 68'(xg_reg)) && (68'(xg_reg) < BAND);
        speed  = (armed_reg && !fell) ? acc_reg : 68'sd0;
        spd_mag = (speed < 0) ? -speed : speed;
        m49     = (spd_mag <<< 5) + (spd_mag <<< 4) + spd_mag;
        msh     = m49 >>> FRAC_BITS;
        sq_try  = root_reg | bit_reg;
        sq_prod = 16'(sq_try) * 16'(sq_try);
    end

    // Divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_val   = prod_sh[31:0];
        div_d     = DIV_BY_TEN;
        unique case (cmd.act)
            ACT_DIV_RATE: begin
                div_start = 1'b1;
            end
            ACT_RATE: begin
                div_start = 1'b1;
                div_val   = div_q;
                div_d     = DIV_BY_MS;
            end
            ACT_PDIV: begin
                div_start = 1'b1;
                div_val   = h_reg;
                div_d     = DIV_BY_GF;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .value   (div_val),
        .divisor (div_d),
        .busy    (div_busy),
        .quot    (div_q)
    );

    assign stat.div_busy  = div_busy;
    assign stat.sqrt_done = bit_reg == 8'd0;

    // Controller state and filter history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_reg    <= '0;
            integ_reg   <= '0;
            armed_reg   <= 1'b0;
            lp_in0_reg  <= '0;
            lp_in1_reg  <= '0;
            lp_out0_reg <= '0;
            lp_out1_reg <= '0;
            bit_reg     <= '0;
        end else begin
            unique case (cmd.act)
                ACT_XF: begin
                    lp_in0_reg  <= lp_in1_reg;
                    lp_in1_reg  <= xg_reg;
                    lp_out0_reg <= lp_out1_reg;
                    lp_out1_reg <= xf_next;
                end
                ACT_COMMIT: begin
                    if (fell) begin
                        armed_reg <= 1'b0;
                    end else if (!armed_reg) begin
                        if (arm_ok) begin
                            tilt_reg  <= xg_reg;
                            integ_reg <= '0;
                            armed_reg <= 1'b1;
                        end
                    end else begin
                        tilt_reg  <= tnew_reg;
                        integ_reg <= inew_reg;
                    end
                    bit_reg <= (msh >= 68'(DUTY_SAT_SQ)) ? 8'd0 : 8'h80;
                end
                ACT_SQRT: begin
                    bit_reg <= bit_reg >> 1;
                end
                default: begin
                end
            endcase
        end
    end

    // Working values
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.acc_op)
            ACC_SET:  acc_reg <= 68'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + 68'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
        unique case (cmd.act)
            ACT_LOAD_IN: begin
                g_reg <= gyro_sample;
                x_reg <= accel_x_sample;
                y_reg <= accel_y_sample;
            end
            ACT_XG:   xg_reg   <= prod_sh[31:0];
            ACT_XR:   xr_reg   <= prod_sh[31:0];
            ACT_YG:   yg_reg   <= prod_sh[31:0];
            ACT_XF:   xf_reg   <= xf_next;
            ACT_H:    h_reg    <= (hv < 0) ? 32'sd0 : hv[31:0];
            ACT_RATE: rate_reg <= div_q;
            ACT_PDIV: pdiv_reg <= div_q;
            ACT_GF:   gf_reg   <= div_q;
            ACT_TNEW: tnew_reg <= tnew_next;
            ACT_INEW: inew_reg <= integ_next[31:0];
            ACT_COMMIT: begin
                fell_reg <= fell;
                dir_reg  <= !(speed < 0);
                if (msh >= 68'(DUTY_SAT_SQ)) begin
                    root_reg <= DUTY_MAX;
                    mag_reg  <= DUTY_SAT_SQ;
                end else begin
                    root_reg <= 8'd0;
                    mag_reg  <= msh[15:0];
                end
            end
            ACT_SQRT: begin
                if (sq_prod <= mag_reg) begin
                    root_reg <= sq_try;
                end
            end
            ACT_LOAD_OUT: begin
                out_data <= {5'd0, fell_reg, armed_reg, root_reg, dir_reg};
            end
            default: begin
            end
        endcase
    end
endmodule

### hdl/bt_ctrl.sv
// Controller: steps the datapath program, the square root and the output handshake.
module bt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  bt_pkg::bt_stat_t stat,
    output bt_pkg::bt_cmd_t  cmd
);
    import bt_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_SQRT, ST_HOLD} state_t;

    state_t  state_reg;
    pc_t     pc_reg;
    logic    out_valid_reg;
    bt_cmd_t step;
    logic    stall;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign step     = prog_step(pc_reg);
    assign stall    = step.wait_div && stat.div_busy;

    always_comb begin
        cmd = CMD_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.act = ACT_LOAD_IN;
                end
            end
            ST_RUN: begin
                if (!stall) begin
                    cmd = step;
                end
            end
            ST_SQRT: begin
                if (!stat.sqrt_done) begin
                    cmd.act = ACT_SQRT;
                end
            end
            ST_HOLD: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.act = ACT_LOAD_OUT;
                end
            end
            default: cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        pc_reg    <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (!stall) begin
                        if (pc_reg == PROG_LAST) begin
                            state_reg <= ST_SQRT;
                        end else begin
                            pc_reg <= pc_reg + 5'd1;
                        end
                    end
                end
                ST_SQRT: begin
                    if (stat.sqrt_done) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### hdl/bt_chk.sv
// Port-level checks of the balance tilt controller, bound to the top level.
module bt_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    // one item at a time: accept closes the input until the result is built
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while an item is in progress");

    a_fall_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[10] && m_tdata[9]))
        else $error("fall reported while armed");

    a_idle_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> m_tdata[0] && (m_tdata[8:1] == 8'd0))
        else $error("drive not zero while disarmed");

    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");
endmodule

bind balance_tilt_controller bt_chk u_bt_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
